### hdl/pulse_completion_tracker_defines.svh
// assertion macros shared by the pulse completion tracker
`ifndef PULSE_COMPLETION_TRACKER_DEFINES_SVH
`define PULSE_COMPLETION_TRACKER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define PCT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pulse completion tracker: same-cycle check failed");

// next-cycle implication, checked out of reset
`define PCT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pulse completion tracker: next-cycle check failed");

`endif

### hdl/pct_pkg.sv
// types and constants of the pulse completion tracker
`default_nettype none

package pct_pkg;

  localparam int unsigned PulseW       = 64;
  localparam int unsigned SeqW         = 16;
  localparam int unsigned NextSeqW     = SeqW + 1;
  localparam int unsigned DupCountBits = 16;
  localparam int unsigned RecDupsW     = 16;
  localparam int unsigned SourceW      = 32;
  localparam int unsigned MaxRecs      = 4;
  localparam int unsigned RecCntW      = $clog2(MaxRecs + 1);
  localparam int unsigned RecIdxW      = $clog2(MaxRecs);

  // item kinds
  typedef enum logic [1:0] {
    FuncRaw      = 2'd0,
    FuncRtdl     = 2'd1,
    FuncLinkDown = 2'd2
  } func_e;

  // record kinds
  typedef enum logic [1:0] {
    KindPartial  = 2'd0,
    KindComplete = 2'd1,
    KindEvents   = 2'd2,
    KindRtdl     = 2'd3
  } kind_e;

  // one input word
  typedef struct packed {
    func_e              func;
    logic [PulseW-1:0]  pulse_id;
    logic [SeqW-1:0]    pkt_seq;
    logic               end_of_pulse;
    logic [2:0]         flavor;
    logic [31:0]        pulse_charge;
    logic [11:0]        veto;
    logic [9:0]         cycle;
    logic [7:0]         timing_status;
    logic [31:0]        intra_time;
    logic [31:0]        tof_offset;
  } item_t;

  // one record without the source id
  typedef struct packed {
    kind_e                   kind;
    logic [PulseW-1:0]       pulse;
    logic [DupCountBits-1:0] dups;
  } rec_t;

  // records caused by one input word, entry 0 goes out first
  typedef struct packed {
    logic [RecCntW-1:0]      cnt;
    rec_t [MaxRecs-1:0]      rec;
  } rec_list_t;

endpackage

`default_nettype wire

### hdl/pct_if.sv
// handshake channels of the pulse completion tracker
`default_nettype none

// input word channel
interface pct_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [63:0] pulse_id;
  logic [15:0] pkt_seq;
  logic        end_of_pulse;
  logic [2:0]  flavor;
  logic [31:0] pulse_charge;
  logic [11:0] veto;
  logic [9:0]  cycle;
  logic [7:0]  timing_status;
  logic [31:0] intra_time;
  logic [31:0] tof_offset;

  modport source (
    output valid, func, pulse_id, pkt_seq, end_of_pulse, flavor, pulse_charge,
           veto, cycle, timing_status, intra_time, tof_offset,
    input  ready
  );
  modport sink (
    input  valid, func, pulse_id, pkt_seq, end_of_pulse, flavor, pulse_charge,
           veto, cycle, timing_status, intra_time, tof_offset,
    output ready
  );
endinterface

// record channel
interface pct_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  record_kind;
  logic [63:0] record_pulse;
  logic [15:0] record_dups;
  logic [31:0] record_source;
  logic        last;

  modport source (
    output valid, record_kind, record_pulse, record_dups, record_source, last,
    input  ready
  );
  modport sink (
    input  valid, record_kind, record_pulse, record_dups, record_source, last,
    output ready
  );
endinterface

// configuration write channel
interface pct_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

### hdl/pulse_completion_tracker.sv
// top level of the pulse completion tracker
// Each input word (raw event header, timing packet or link-down) is taken into an input
// register, evaluated against the pulse state and turned into zero to four records held
// in a record buffer that drains one word per cycle on the output channel while the
// output is ready. A word causes one to four records or none, and a raw header that
// closes a pulse causes up to four; the output port, one record per cycle while ready,
// sets the sustained rate. The next input word is taken while records of the previous
// one are still waiting. There is no clearing pass after reset. The source id register
// may only be written while idle and is copied onto every record.
`default_nettype none

`include "pulse_completion_tracker_defines.svh"

module pulse_completion_tracker (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  pct_in_if.sink      in_i,
  pct_cfg_if.sink     cfg_i,
  pct_out_if.source   out_o
);

  pct_pkg::item_t                      item_q;
  logic                                item_valid_q;
  logic [pct_pkg::RecCntW-1:0]         cnt_q;
  pct_pkg::rec_t [pct_pkg::MaxRecs-1:0] rec_q;
  logic [pct_pkg::SourceW-1:0]         source_q;
  pct_pkg::rec_list_t                  list;
  logic                                pop;
  logic                                pop_last;
  logic                                fire;

  // handshake decisions
  assign pop      = out_o.valid && out_o.ready;
  assign pop_last = pop && (cnt_q == pct_pkg::RecCntW'(1));
  assign fire     = item_valid_q && ((cnt_q == '0) || pop_last);
  assign in_i.ready  = !item_valid_q || fire;
  assign cfg_i.ready = 1'b1;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      source_q <= '0;
    end else if (cfg_i.valid) begin
      source_q <= cfg_i.data;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      item_valid_q <= 1'b1;
    end else if (fire) begin
      item_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.func          <= pct_pkg::func_e'(in_i.func);
      item_q.pulse_id      <= in_i.pulse_id;
      item_q.pkt_seq       <= in_i.pkt_seq;
      item_q.end_of_pulse  <= in_i.end_of_pulse;
      item_q.flavor        <= in_i.flavor;
      item_q.pulse_charge  <= in_i.pulse_charge;
      item_q.veto          <= in_i.veto;
      item_q.cycle         <= in_i.cycle;
      item_q.timing_status <= in_i.timing_status;
      item_q.intra_time    <= in_i.intra_time;
      item_q.tof_offset    <= in_i.tof_offset;
    end
  end

  // tracking state and record generation
  pct_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (item_q),
    .list_o (list)
  );

  // record buffer count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (fire) begin
      cnt_q <= list.cnt;
    end else if (pop) begin
      cnt_q <= cnt_q - pct_pkg::RecCntW'(1);
    end
  end

  // record buffer entries, shifted down as each word leaves
  always_ff @(posedge clk_i) begin
    if (fire) begin
      rec_q <= list.rec;
    end else if (pop) begin
      rec_q <= rec_q >> $bits(pct_pkg::rec_t);
    end
  end

  // output word
  assign out_o.valid         = (cnt_q != '0);
  assign out_o.record_kind   = rec_q[0].kind;
  assign out_o.record_pulse  = rec_q[0].pulse;
  assign out_o.record_dups   = pct_pkg::RecDupsW'(rec_q[0].dups);
  assign out_o.record_source = source_q;
  assign out_o.last          = (cnt_q == pct_pkg::RecCntW'(1));

  // a drained buffer stays empty unless a new word is evaluated
  `PCT_ASSERT_NEXT(a_drain_empty, pop_last && !fire, cnt_q == '0)
  // a raw header always yields at least its forward record
  `PCT_ASSERT_NOW(a_raw_has_rec, fire && (item_q.func == pct_pkg::FuncRaw), list.cnt != '0)
  // a non-final pop removes exactly one entry
  `PCT_ASSERT_NEXT(a_pop_one, pop && !pop_last && !fire,
                   (cnt_q + pct_pkg::RecCntW'(1)) == $past(cnt_q))

endmodule

`default_nettype wire

### hdl/pct_core.sv
// pulse tracking state and the records that one input word causes
`default_nettype none

module pct_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              fire_i,
  input  wire pct_pkg::item_t    item_i,
  output pct_pkg::rec_list_t     list_o
);

  logic                             fresh_q, fresh_d;
  logic [pct_pkg::PulseW-1:0]       cur_q, cur_d;
  logic [pct_pkg::DupCountBits-1:0] dup_q, dup_d;
  logic [pct_pkg::NextSeqW-1:0]     next_q, next_d;
  logic                             done_q, done_d;
  logic                             latch;

  logic [2:0]  held_flavor_q;
  logic [31:0] held_charge_q;
  logic [11:0] held_veto_q;
  logic [9:0]  held_cycle_q;
  logic [7:0]  held_status_q;
  logic [31:0] held_intra_q;
  logic [31:0] held_tof_q;

  // close decision, record list and next state
  always_comb begin
    logic                       same_inv;
    logic                       same_id;
    logic                       close_req;
    logic                       close_dup;
    logic                       closing;
    logic [pct_pkg::RecCntW-1:0] n;
    logic [pct_pkg::NextSeqW-1:0] seq_x;

    same_id  = (item_i.pulse_id == cur_q);
    same_inv = (item_i.flavor == held_flavor_q) && (item_i.pulse_charge == held_charge_q) &&
               (item_i.veto == held_veto_q) && (item_i.cycle == held_cycle_q) &&
               (item_i.timing_status == held_status_q) &&
               (item_i.intra_time == held_intra_q) && (item_i.tof_offset == held_tof_q);
    seq_x    = {1'b0, item_i.pkt_seq};

    unique case (item_i.func)
      pct_pkg::FuncRaw: begin
        close_req = !fresh_q && (!same_id || done_q || (seq_x < next_q) || !same_inv);
        close_dup = same_id;
      end
      pct_pkg::FuncRtdl: begin
        close_req = 1'b1;
        close_dup = same_id;
      end
      pct_pkg::FuncLinkDown: begin
        close_req = 1'b1;
        close_dup = 1'b0;
      end
      default: begin
        close_req = 1'b0;
        close_dup = 1'b0;
      end
    endcase
    closing = close_req && (cur_q != '0);

    list_o = '0;
    n      = '0;
    fresh_d = fresh_q;
    cur_d   = cur_q;
    dup_d   = dup_q;
    next_d  = next_q;
    done_d  = done_q;
    latch   = 1'b0;

    // closing records carry the old duplicate count
    if (closing) begin
      if (!done_q) begin
        list_o.rec[n[pct_pkg::RecIdxW-1:0]] = '{kind: pct_pkg::KindPartial, pulse: cur_q,
                                                 dups: dup_q};
        n = n + pct_pkg::RecCntW'(1);
      end
      list_o.rec[n[pct_pkg::RecIdxW-1:0]] = '{kind: pct_pkg::KindComplete, pulse: cur_q,
                                               dups: dup_q};
      n = n + pct_pkg::RecCntW'(1);
      fresh_d = 1'b1;
      next_d  = '0;
      done_d  = 1'b0;
      if (close_dup) begin
        dup_d = (dup_q == '1) ? dup_q : dup_q + pct_pkg::DupCountBits'(1);
      end else begin
        dup_d = '0;
      end
    end

    // word-specific updates and trailing records
    unique case (item_i.func)
      pct_pkg::FuncRaw: begin
        if (fresh_d) begin
          latch   = 1'b1;
          fresh_d = 1'b0;
          cur_d   = item_i.pulse_id;
        end
        if (seq_x != next_d) begin
          list_o.rec[n[pct_pkg::RecIdxW-1:0]] = '{kind: pct_pkg::KindPartial,
                                                   pulse: item_i.pulse_id, dups: dup_d};
          n = n + pct_pkg::RecCntW'(1);
        end
        next_d = seq_x + pct_pkg::NextSeqW'(1);
        done_d = done_d | item_i.end_of_pulse;
        list_o.rec[n[pct_pkg::RecIdxW-1:0]] = '{kind: pct_pkg::KindEvents,
                                                 pulse: item_i.pulse_id, dups: dup_d};
        n = n + pct_pkg::RecCntW'(1);
      end
      pct_pkg::FuncRtdl: begin
        cur_d = item_i.pulse_id;
        list_o.rec[n[pct_pkg::RecIdxW-1:0]] = '{kind: pct_pkg::KindRtdl,
                                                 pulse: item_i.pulse_id, dups: dup_d};
        n = n + pct_pkg::RecCntW'(1);
      end
      pct_pkg::FuncLinkDown: begin
        cur_d   = '0;
        fresh_d = 1'b1;
      end
      default: begin
        fresh_d = fresh_q;
      end
    endcase
    list_o.cnt = n;
  end

  // tracking state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q <= 1'b1;
      cur_q   <= '0;
      dup_q   <= '0;
      next_q  <= '0;
      done_q  <= 1'b0;
    end else if (fire_i) begin
      fresh_q <= fresh_d;
      cur_q   <= cur_d;
      dup_q   <= dup_d;
      next_q  <= next_d;
      done_q  <= done_d;
    end
  end

  // invariant header fields of the current pulse
  always_ff @(posedge clk_i) begin
    if (fire_i && latch) begin
      held_flavor_q <= item_i.flavor;
      held_charge_q <= item_i.pulse_charge;
      held_veto_q   <= item_i.veto;
      held_cycle_q  <= item_i.cycle;
      held_status_q <= item_i.timing_status;
      held_intra_q  <= item_i.intra_time;
      held_tof_q    <= item_i.tof_offset;
    end
  end

endmodule

`default_nettype wire
